FILE: src/imu_serial_frame_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// IMU serial frame decoder: assertion macros
// Shared property forms, clocked on clk with reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef IMU_SERIAL_FRAME_DECODER_UNIT_DEFINES_SVH
`define IMU_SERIAL_FRAME_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define IMUSFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imusfd: same-cycle check failed");

// next-cycle implication
`define IMUSFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imusfd: next-cycle check failed");

`endif

FILE: src/imusfd_pkg.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder package
// Frame codes, scale constants and the stage payload type.
// ----------------------------------------------------------------------------
`default_nettype none

package imusfd_pkg;

    localparam int FRAME_LENGTH = 11;
    // bytes 1..9 are kept; the header falls off the end and the checksum is not captured
    localparam int CELL_COUNT   = FRAME_LENGTH - 2;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_GYRO   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic signed [12:0] SCALE_ACCEL = 13'sd16;
    localparam logic signed [12:0] SCALE_GYRO  = 13'sd2000;
    localparam logic signed [12:0] SCALE_ANGLE = 13'sd180;

    // temperature: floor((raw*128 + 85 + 17000000) / 170) - 100000 + 9280
    // numerator/2 = raw*64 + TEMP_OFFSET, then divide by 85 via reciprocal
    localparam logic [23:0] TEMP_OFFSET = 24'd8500042;
    localparam logic [24:0] TEMP_RECIP  = 25'd25264514;  // ceil(2^31 / 85)
    localparam int          RECIP_SHIFT = 31;
    localparam logic [17:0] TEMP_BIAS   = 18'd90720;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [15:0] raw_z;
        logic [23:0] temp_half;
    } frame_t;

    function automatic logic signed [12:0] kind_scale(input logic [1:0] kind);
        logic signed [12:0] s;
        case (kind)
            KIND_ACCEL: s = SCALE_ACCEL;
            KIND_GYRO:  s = SCALE_GYRO;
            KIND_ANGLE: s = SCALE_ANGLE;
            default:    s = 13'sd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: src/imu_serial_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder
// Parses 11-byte sensor frames into scaled acceleration, rate or angle items.
// ----------------------------------------------------------------------------
// One received byte is taken per clock. Bytes shift through a chain of nine
// byte cells while a frame is gathered; hunting drops everything but a 0x55
// header. On the eleventh byte a known type (0x51/0x52/0x53) produces one item
// of three Q.8 axes and a Q.8 temperature; unknown types produce nothing and
// the checksum is not checked. The frame fields go into the capture register,
// are multiplied into the multiply-stage registers and are rounded into the
// output register, where the item waits to be accepted.
// A new byte can be taken every cycle; input ready drops only while the
// capture register holds an item that the stalled output pipeline cannot move
// on.
`default_nettype none

module imu_serial_frame_decoder_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         rx_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              packet_kind,
    output logic signed [19:0]      axis_x,
    output logic signed [19:0]      axis_y,
    output logic signed [19:0]      axis_z,
    output logic signed [16:0]      temperature
);

    logic [7:0]          cell_q [imusfd_pkg::CELL_COUNT];
    logic [3:0]          count_reg;
    logic [3:0]          count_next;
    logic                byte_take;
    logic                hunting;
    logic                take_byte;
    logic                frame_done;
    logic [1:0]          type_kind;
    logic                done_known;
    logic                hunt_drop;

    logic                cap_valid_reg;
    logic                cap_valid_next;
    imusfd_pkg::frame_t  cap_reg;
    imusfd_pkg::frame_t  cap_next;
    logic                scale_ready;
    logic                cap_ready;

    assign byte_take  = in_valid && in_ready;
    // an out-of-range count counts as hunting
    assign hunting    = (count_reg == 4'd0) ||
                        (count_reg >= 4'(imusfd_pkg::FRAME_LENGTH));
    assign take_byte  = byte_take && (!hunting || (rx_byte == imusfd_pkg::HEADER_BYTE));
    assign frame_done = take_byte && !hunting &&
                        (count_reg == 4'(imusfd_pkg::FRAME_LENGTH - 1));
    assign hunt_drop  = byte_take && (count_reg == 4'd0) &&
                        (rx_byte != imusfd_pkg::HEADER_BYTE);

    always_comb
    begin
        count_next = count_reg;
        if (byte_take && hunting)
        begin
            count_next = (rx_byte == imusfd_pkg::HEADER_BYTE) ? 4'd1 : 4'd0;
        end
        else if (frame_done)
        begin
            count_next = 4'd0;
        end
        else if (take_byte)
        begin
            count_next = count_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < imusfd_pkg::CELL_COUNT; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                imusfd_byte_cell u_cell (
                    .clk      (clk),
                    .shift_en (take_byte),
                    .byte_in  (rx_byte),
                    .byte_out (cell_q[gi])
                );
            end
            else
            begin : g_link
                imusfd_byte_cell u_cell (
                    .clk      (clk),
                    .shift_en (take_byte),
                    .byte_in  (cell_q[gi-1]),
                    .byte_out (cell_q[gi])
                );
            end
        end
    endgenerate

    // on the last byte: cell 0 holds byte 9 ... cell 8 holds byte 1 (type)
    always_comb
    begin
        case (cell_q[8])
            imusfd_pkg::TYPE_ACCEL: type_kind = imusfd_pkg::KIND_ACCEL;
            imusfd_pkg::TYPE_GYRO:  type_kind = imusfd_pkg::KIND_GYRO;
            imusfd_pkg::TYPE_ANGLE: type_kind = imusfd_pkg::KIND_ANGLE;
            default:                type_kind = imusfd_pkg::KIND_NONE;
        endcase
    end

    assign done_known = frame_done && (type_kind != imusfd_pkg::KIND_NONE);

    always_comb
    begin
        cap_next.kind      = type_kind;
        cap_next.raw_x     = {cell_q[6], cell_q[7]};
        cap_next.raw_y     = {cell_q[4], cell_q[5]};
        cap_next.raw_z     = {cell_q[2], cell_q[3]};
        cap_next.temp_half = {{2{cell_q[0][7]}}, cell_q[0], cell_q[1], 6'b0}
                             + imusfd_pkg::TEMP_OFFSET;
    end

    assign cap_ready = !cap_valid_reg || scale_ready;
    assign in_ready  = cap_ready;

    always_comb
    begin
        cap_valid_next = cap_valid_reg;
        if (cap_ready)
        begin
            cap_valid_next = done_known;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            cap_valid_reg <= cap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_known)
        begin
            cap_reg <= cap_next;
        end
    end

    imusfd_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (cap_valid_reg),
        .frame_ready (scale_ready),
        .frame       (cap_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .packet_kind (packet_kind),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .axis_z      (axis_z),
        .temperature (temperature)
    );

`include "imu_serial_frame_decoder_unit_defines.svh"

    `IMUSFD_ASSERT_NEXT(a_hunt_drop, hunt_drop, count_reg == 4'd0)
    `IMUSFD_ASSERT_NEXT(a_known_captured, done_known, cap_valid_reg)
    `IMUSFD_ASSERT_SAME(a_stall_only_full, !in_ready, cap_valid_reg)
    `IMUSFD_ASSERT_SAME(a_kind_known, out_valid, packet_kind != imusfd_pkg::KIND_NONE)

endmodule

`default_nettype wire

FILE: src/imusfd_byte_cell.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder: byte cell
// One link of the frame shift chain; takes its input byte on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module imusfd_byte_cell (
    input  wire logic       clk,
    input  wire logic       shift_en,
    input  wire logic [7:0] byte_in,
    output logic      [7:0] byte_out
);

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= byte_in;
        end
    end

    assign byte_out = data_reg;

endmodule

`default_nettype wire

FILE: src/imusfd_scale.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder: scaling pipeline
// Multiply stage, then rounding and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imusfd_scale (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  frame_valid,
    output logic                       frame_ready,
    input  wire imusfd_pkg::frame_t    frame,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 packet_kind,
    output logic signed [19:0]         axis_x,
    output logic signed [19:0]         axis_y,
    output logic signed [19:0]         axis_z,
    output logic signed [16:0]         temperature
);

    // multiply stage
    logic               mul_valid_reg;
    logic               mul_valid_next;
    logic [1:0]         mul_kind_reg;
    logic signed [28:0] prod_x_reg;
    logic signed [28:0] prod_y_reg;
    logic signed [28:0] prod_z_reg;
    logic [48:0]        prod_t_reg;
    logic signed [12:0] scale;
    logic               mul_ready;

    // output stage
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         kind_reg;
    logic signed [19:0] x_reg;
    logic signed [19:0] y_reg;
    logic signed [19:0] z_reg;
    logic signed [16:0] temp_reg;
    logic               out_stage_ready;

    logic signed [28:0] round_x;
    logic signed [28:0] round_y;
    logic signed [28:0] round_z;
    logic [17:0]        temp_sum;

    assign scale           = imusfd_pkg::kind_scale(frame.kind);
    assign out_stage_ready = !out_valid_reg || out_ready;
    assign mul_ready       = !mul_valid_reg || out_stage_ready;
    assign frame_ready     = mul_ready;

    always_comb
    begin
        mul_valid_next = mul_valid_reg;
        if (mul_ready)
        begin
            mul_valid_next = frame_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_stage_ready)
        begin
            out_valid_next = mul_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && frame_valid)
        begin
            mul_kind_reg <= frame.kind;
            prod_x_reg   <= $signed(frame.raw_x) * scale;
            prod_y_reg   <= $signed(frame.raw_y) * scale;
            prod_z_reg   <= $signed(frame.raw_z) * scale;
            prod_t_reg   <= 49'(frame.temp_half) * 49'(imusfd_pkg::TEMP_RECIP);
        end
    end

    // round half up, then arithmetic shift by 7
    assign round_x  = prod_x_reg + 29'sd64;
    assign round_y  = prod_y_reg + 29'sd64;
    assign round_z  = prod_z_reg + 29'sd64;
    assign temp_sum = {1'b0, prod_t_reg[imusfd_pkg::RECIP_SHIFT +: 17]}
                      - imusfd_pkg::TEMP_BIAS;

    always_ff @(posedge clk)
    begin
        if (out_stage_ready && mul_valid_reg)
        begin
            kind_reg <= mul_kind_reg;
            x_reg    <= round_x[26:7];
            y_reg    <= round_y[26:7];
            z_reg    <= round_z[26:7];
            temp_reg <= temp_sum[16:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign packet_kind = kind_reg;
    assign axis_x      = x_reg;
    assign axis_y      = y_reg;
    assign axis_z      = z_reg;
    assign temperature = temp_reg;

endmodule

`default_nettype wire
